@@ rtl/rc4sk_pkg.sv @@
// Package for the seeded RC4 keystream word block.
// Holds sizes, the controller state and datapath operation types, and the status struct.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package rc4sk_pkg;

    localparam int STATE_SIZE = 256;
    localparam int SBOX_AW    = $clog2(STATE_SIZE);
    localparam int KEY_LEN    = 40;
    localparam int KIDX_W     = $clog2(KEY_LEN);
    localparam int OUT_BYTES  = 8;
    localparam int BYTE_IDX_W = $clog2(OUT_BYTES);
    localparam int SEED_W     = 8;
    localparam int WORD_W     = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_J,
        ST_KS_SWAP1,
        ST_KS_SWAP2,
        ST_PR_J,
        ST_PR_SWAP1,
        ST_PR_SWAP2,
        ST_PR_OUT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL,
        OP_KS_J,
        OP_KS_SWAP1,
        OP_KS_SWAP2,
        OP_PR_J,
        OP_PR_SWAP1,
        OP_PR_SWAP2,
        OP_PR_OUT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic cnt_last;
        logic byte_last;
        logic out_free;
    } dp_status_t;

endpackage : rc4sk_pkg

`default_nettype wire

@@ rtl/rc4sk_seed_if.sv @@
// Input channel interface: carries the two seed bytes with valid and ready.
// Depends on rc4sk_pkg for the seed width.
`timescale 1ns / 1ps
`default_nettype none

interface rc4sk_seed_if;
    logic                           valid;
    logic                           ready;
    logic [rc4sk_pkg::SEED_W-1:0]   seed_a;
    logic [rc4sk_pkg::SEED_W-1:0]   seed_b;

    modport source (output valid, output seed_a, output seed_b, input ready);
    modport sink   (input valid, input seed_a, input seed_b, output ready);
endinterface : rc4sk_seed_if

`default_nettype wire

@@ rtl/rc4sk_word_if.sv @@
// Output channel interface: carries the 64-bit keystream word with valid and ready.
// Depends on rc4sk_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

interface rc4sk_word_if;
    logic                           valid;
    logic                           ready;
    logic [rc4sk_pkg::WORD_W-1:0]   keystream_word;

    modport source (output valid, output keystream_word, input ready);
    modport sink   (input valid, input keystream_word, output ready);
endinterface : rc4sk_word_if

`default_nettype wire

@@ rtl/rc4sk_datapath.sv @@
// Datapath: state memory, key register, RC4 indices and the output register.
// Executes one operation per cycle as commanded; depends on rc4sk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rc4sk_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rc4sk_pkg::dp_op_t                  op,
    input  wire logic [rc4sk_pkg::SEED_W-1:0]       seed_a,
    input  wire logic [rc4sk_pkg::SEED_W-1:0]       seed_b,
    input  wire logic                               out_ready,
    output rc4sk_pkg::dp_status_t                   status,
    output logic                                    out_valid,
    output logic [rc4sk_pkg::WORD_W-1:0]            keystream_word
);

    localparam int AW         = rc4sk_pkg::SBOX_AW;
    localparam int KIDX_W     = rc4sk_pkg::KIDX_W;
    localparam int BYTE_IDX_W = rc4sk_pkg::BYTE_IDX_W;

    // State memory: one write and one registered read per cycle, write-first.
    logic [7:0] sbox_mem [rc4sk_pkg::STATE_SIZE];
    logic [7:0] rdata_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    j_sum;
    logic [15:0]   seed_prod;
    logic [7:0]    seed_s2;
    logic [7:0]    seed_s3;
    logic [7:0]    seed_s4;

    logic [AW-1:0]                      cnt_reg,   cnt_next;
    logic [AW-1:0]                      i_reg,     i_next;
    logic [AW-1:0]                      j_reg,     j_next;
    logic [7:0]                         tmp_reg,   tmp_next;
    logic [7:0]                         sj_reg,    sj_next;
    logic [rc4sk_pkg::KIDX_W-1:0]       kidx_reg,  kidx_next;
    logic [rc4sk_pkg::BYTE_IDX_W-1:0]   kbyte_reg, kbyte_next;
    logic [rc4sk_pkg::KEY_LEN-1:0]      key_reg,   key_next;
    logic [rc4sk_pkg::WORD_W-1:0]       word_reg,  word_next;
    logic [rc4sk_pkg::WORD_W-1:0]       out_word_reg, out_word_next;
    logic                               out_valid_reg, out_valid_next;

    always_comb
    begin
        seed_prod = seed_a * seed_b;
        seed_s2   = seed_prod[7:0];
        seed_s3   = seed_a + seed_b;
        seed_s4   = seed_s2 + seed_s3;
    end

    always_comb
    begin
        we             = 1'b0;
        waddr          = cnt_reg;
        wdata          = cnt_reg;
        raddr          = cnt_reg;
        j_sum          = j_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        tmp_next       = tmp_reg;
        sj_next        = sj_reg;
        kidx_next      = kidx_reg;
        kbyte_next     = kbyte_reg;
        key_next       = key_reg;
        word_next      = word_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (op)
            rc4sk_pkg::OP_LOAD:
            begin
                key_next  = {seed_s4, seed_s3, seed_s2, seed_b, seed_a};
                cnt_next  = '0;
                j_next    = '0;
                kidx_next = '0;
            end
            rc4sk_pkg::OP_FILL:
            begin
                // Identity fill; entry zero is read ahead for the first schedule step.
                we       = 1'b1;
                waddr    = cnt_reg;
                wdata    = cnt_reg;
                raddr    = '0;
                cnt_next = cnt_reg + 1'b1;
            end
            rc4sk_pkg::OP_KS_J:
            begin
                j_sum    = j_reg + rdata_reg + 8'(key_reg[kidx_reg]);
                j_next   = j_sum;
                tmp_next = rdata_reg;
                raddr    = j_sum;
            end
            rc4sk_pkg::OP_KS_SWAP1:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = rdata_reg;
            end
            rc4sk_pkg::OP_KS_SWAP2:
            begin
                we        = 1'b1;
                waddr     = j_reg;
                wdata     = tmp_reg;
                cnt_next  = cnt_reg + 1'b1;
                kidx_next = (kidx_reg == KIDX_W'(rc4sk_pkg::KEY_LEN - 1)) ?
                            '0 : kidx_reg + 1'b1;
                if (cnt_reg == AW'(rc4sk_pkg::STATE_SIZE - 1))
                begin
                    // Schedule done: the keystream starts with i = 1 and j = 0.
                    raddr      = AW'(1);
                    i_next     = AW'(1);
                    j_next     = '0;
                    kbyte_next = '0;
                end
                else
                begin
                    raddr = cnt_reg + 1'b1;
                end
            end
            rc4sk_pkg::OP_PR_J:
            begin
                j_sum    = j_reg + rdata_reg;
                j_next   = j_sum;
                tmp_next = rdata_reg;
                raddr    = j_sum;
            end
            rc4sk_pkg::OP_PR_SWAP1:
            begin
                we      = 1'b1;
                waddr   = i_reg;
                wdata   = rdata_reg;
                sj_next = rdata_reg;
            end
            rc4sk_pkg::OP_PR_SWAP2:
            begin
                // The swap leaves the sum of the two entries unchanged.
                we    = 1'b1;
                waddr = j_reg;
                wdata = tmp_reg;
                raddr = tmp_reg + sj_reg;
            end
            rc4sk_pkg::OP_PR_OUT:
            begin
                word_next[kbyte_reg*8 +: 8] = rdata_reg;
                kbyte_next = kbyte_reg + 1'b1;
                raddr      = i_reg + 1'b1;
                if (kbyte_reg != BYTE_IDX_W'(rc4sk_pkg::OUT_BYTES - 1))
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            rc4sk_pkg::OP_EMIT:
            begin
                out_word_next  = word_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sbox_mem[waddr] <= wdata;
        end
        rdata_reg <= (we && waddr == raddr) ? wdata : sbox_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            kidx_reg      <= '0;
            kbyte_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            kidx_reg      <= kidx_next;
            kbyte_reg     <= kbyte_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg      <= tmp_next;
        sj_reg       <= sj_next;
        key_reg      <= key_next;
        word_reg     <= word_next;
        out_word_reg <= out_word_next;
    end

    assign status.cnt_last  = (cnt_reg == AW'(rc4sk_pkg::STATE_SIZE - 1));
    assign status.byte_last = (kbyte_reg == BYTE_IDX_W'(rc4sk_pkg::OUT_BYTES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign keystream_word   = out_word_reg;

    // The key bit index never leaves the key.
    a_kidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        kidx_reg < KIDX_W'(rc4sk_pkg::KEY_LEN))
        else $error("key bit index out of range");

    // An emitted word is presented in the following cycle.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op == rc4sk_pkg::OP_EMIT |=> out_valid_reg)
        else $error("emitted word not presented");

    // A new word is never loaded over one that is still waiting to be taken.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == rc4sk_pkg::OP_EMIT |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

endmodule : rc4sk_datapath

`default_nettype wire

@@ rtl/rc4sk_ctrl.sv @@
// Controller: sequences fill, key schedule and keystream phases of one transaction.
// Issues one datapath operation per cycle, OP_NONE while idle or while a word waits in ST_DONE; depends on rc4sk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rc4sk_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire rc4sk_pkg::dp_status_t  status,
    output rc4sk_pkg::dp_op_t           op
);

    rc4sk_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4sk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = rc4sk_pkg::OP_NONE;
        in_ready   = 1'b0;

        unique case (state_reg)
            rc4sk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = rc4sk_pkg::OP_LOAD;
                    state_next = rc4sk_pkg::ST_FILL;
                end
            end
            rc4sk_pkg::ST_FILL:
            begin
                op = rc4sk_pkg::OP_FILL;
                if (status.cnt_last)
                begin
                    state_next = rc4sk_pkg::ST_KS_J;
                end
            end
            rc4sk_pkg::ST_KS_J:
            begin
                op         = rc4sk_pkg::OP_KS_J;
                state_next = rc4sk_pkg::ST_KS_SWAP1;
            end
            rc4sk_pkg::ST_KS_SWAP1:
            begin
                op         = rc4sk_pkg::OP_KS_SWAP1;
                state_next = rc4sk_pkg::ST_KS_SWAP2;
            end
            rc4sk_pkg::ST_KS_SWAP2:
            begin
                op         = rc4sk_pkg::OP_KS_SWAP2;
                state_next = status.cnt_last ? rc4sk_pkg::ST_PR_J : rc4sk_pkg::ST_KS_J;
            end
            rc4sk_pkg::ST_PR_J:
            begin
                op         = rc4sk_pkg::OP_PR_J;
                state_next = rc4sk_pkg::ST_PR_SWAP1;
            end
            rc4sk_pkg::ST_PR_SWAP1:
            begin
                op         = rc4sk_pkg::OP_PR_SWAP1;
                state_next = rc4sk_pkg::ST_PR_SWAP2;
            end
            rc4sk_pkg::ST_PR_SWAP2:
            begin
                op         = rc4sk_pkg::OP_PR_SWAP2;
                state_next = rc4sk_pkg::ST_PR_OUT;
            end
            rc4sk_pkg::ST_PR_OUT:
            begin
                op         = rc4sk_pkg::OP_PR_OUT;
                state_next = status.byte_last ? rc4sk_pkg::ST_DONE : rc4sk_pkg::ST_PR_J;
            end
            rc4sk_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    op         = rc4sk_pkg::OP_EMIT;
                    state_next = rc4sk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4sk_pkg::ST_IDLE;
            end
        endcase
    end

    // An accepted seed always starts the identity fill.
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == rc4sk_pkg::ST_FILL)
        else $error("accepted seed did not start the fill");

    // A finished word waits while the output register is occupied.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rc4sk_pkg::ST_DONE && !status.out_free
        |=> state_reg == rc4sk_pkg::ST_DONE)
        else $error("finished word left without an output slot");

    // The schedule leaves for the keystream phase only after its last step.
    a_ks_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rc4sk_pkg::ST_KS_SWAP2 && !status.cnt_last
        |=> state_reg == rc4sk_pkg::ST_KS_J)
        else $error("key schedule ended early");

endmodule : rc4sk_ctrl

`default_nettype wire

@@ rtl/rc4_seeded_keystream_word.sv @@
// Seeded RC4 keystream word generator: top level joining controller and datapath.
// Depends on rc4sk_pkg, rc4sk_seed_if, rc4sk_word_if, rc4sk_ctrl and rc4sk_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the seed channel carries two bytes, seed_a and seed_b. From
// them the block forms a five-byte seed (a, b, a*b, a+b and the sum of the last two,
// all modulo 256), uses its 40 bits, least significant bit of each byte first, as a
// repeating one-bit-per-step key, and runs the RC4 key schedule over a 256-entry
// state that starts as the identity for every transaction. The first eight keystream
// bytes are then returned as one 64-bit word on the keystream channel, first byte in
// bits 7:0. Transactions are independent of one another. After acceptance the block
// fills the state memory, runs the 256 schedule steps, forms each keystream byte and
// moves the word into the output register, each phase paced by the single write port
// and single registered read port of the state memory. A new seed is accepted the
// cycle after the previous word has been placed in the output register, so a seed is
// taken only once the previous one is through; a word left waiting holds the block
// only once the next one is ready to replace it. There is no clearing pass after
// reset: every transaction rewrites the state memory before reading it.
module rc4_seeded_keystream_word (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rc4sk_seed_if.sink  seed,
    rc4sk_word_if.source keystream
);

    rc4sk_pkg::dp_op_t      op;
    rc4sk_pkg::dp_status_t  status;
    logic                   seed_ready;
    logic                   word_valid;
    logic [rc4sk_pkg::WORD_W-1:0] word_data;

    // The controller steps through the phases and issues one datapath operation a cycle.
    rc4sk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seed.valid),
        .in_ready (seed_ready),
        .status   (status),
        .op       (op)
    );

    // The datapath holds the state memory, the key, the indices and the result register.
    rc4sk_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .seed_a         (seed.seed_a),
        .seed_b         (seed.seed_b),
        .out_ready      (keystream.ready),
        .status         (status),
        .out_valid      (word_valid),
        .keystream_word (word_data)
    );

    assign seed.ready               = seed_ready;
    assign keystream.valid          = word_valid;
    assign keystream.keystream_word = word_data;

endmodule : rc4_seeded_keystream_word

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the seeded RC4 keystream word block.
// Depends on rc4sk_pkg, rc4sk_seed_if, rc4sk_word_if and rc4_seeded_keystream_word.
// Seeds go in on the seed channel; every returned word is checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int SEED_W     = rc4sk_pkg::SEED_W;
    localparam int WORD_W     = rc4sk_pkg::WORD_W;
    localparam int STATE_SIZE = rc4sk_pkg::STATE_SIZE;
    localparam int KEY_LEN    = rc4sk_pkg::KEY_LEN;
    localparam int OUT_BYTES  = rc4sk_pkg::OUT_BYTES;

    // The tail wait at the end covers one full item; anything arriving in that window
    // is a spurious word.
    localparam int DRAIN_CYCLES = 1100;

    // Slowest correct run: about 750 items, each with the full work of one seed, the longest
    // sender gap and the longest receiver stall, on a clock of 8 ns; the limit is several
    // times that.
    localparam int RUN_LIMIT_NS = 80_000_000;

    // Receiver behaviour on the keystream channel.
    typedef enum logic [1:0] {
        STALL_NONE,     // always ready
        STALL_SHORT,    // frequent short stalls
        STALL_LONG      // rare long stalls, so the block itself can be held
    } stall_mode_t;

    // What one accepted seed transaction is expected to return.
    typedef struct {
        logic [SEED_W-1:0] seed_a;
        logic [SEED_W-1:0] seed_b;
        logic [WORD_W-1:0] word;
    } keystream_expect_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rc4sk_seed_if seed_bus ();
    rc4sk_word_if word_bus ();

    rc4_seeded_keystream_word DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_bus.sink),
        .keystream (word_bus.source)
    );

    always #4 clk = ~clk;

    keystream_expect_t expected_words [$];
    int                mismatch_count = 0;

    // Sender pacing: when gaps are enabled the sender works in bursts of random length
    // and rests for a random number of cycles after each burst.
    bit                gaps_on    = 1'b0;
    int                burst_left = 0;
    bit                seed_held  = 1'b0;

    // Receiver pacing.
    stall_mode_t       stall_mode = STALL_NONE;
    int                stall_left = 0;

    // Private copy of the block's state, rebuilt by the predictor for every seed.
    logic [7:0]        perm [0:STATE_SIZE-1];
    logic [7:0]        ks_i;
    logic [7:0]        ks_j;
    logic [KEY_LEN-1:0] key_bits;

    // Computes the keystream word for one seed pair. The five seed bytes are packed
    // least significant first, so key bit n is simply bit n of the 40-bit key, and each
    // schedule step adds a single key bit rather than a key byte.
    function automatic logic [WORD_W-1:0] rc4_keystream(input logic [SEED_W-1:0] a,
                                                        input logic [SEED_W-1:0] b);
        logic [7:0]        prod;
        logic [7:0]        sum;
        logic [7:0]        mix;
        logic [7:0]        j;
        logic [7:0]        t;
        logic [WORD_W-1:0] word;
        prod     = a * b;
        sum      = a + b;
        mix      = prod + sum;
        key_bits = {mix, sum, prod, b, a};
        for (int n = 0; n < STATE_SIZE; n++)
            perm[n] = 8'(n);
        j = 8'd0;
        for (int n = 0; n < STATE_SIZE; n++)
        begin
            j       = j + perm[n] + 8'(key_bits[n % KEY_LEN]);
            t       = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        ks_i = 8'd0;
        ks_j = 8'd0;
        word = '0;
        for (int k = 0; k < OUT_BYTES; k++)
        begin
            ks_i          = ks_i + 8'd1;
            ks_j          = ks_j + perm[ks_i];
            t             = perm[ks_i];
            perm[ks_i]    = perm[ks_j];
            perm[ks_j]    = t;
            t             = perm[ks_i] + perm[ks_j];
            word[8*k +: 8] = perm[t];
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Mostly uniform bytes, with the edges of the range mixed in now and then.
    function automatic logic [SEED_W-1:0] pick_seed_byte();
        logic [SEED_W-1:0] edges [5];
        edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Presents one seed transaction and waits for the edge where it is accepted, where
    // the expectation is queued; a rest may follow. Valid stays high into the next call while
    // a burst lasts, so back-to-back transactions need no extra assignment.
    task automatic send_seed(input logic [SEED_W-1:0] a, input logic [SEED_W-1:0] b);
        int gap;
        seed_bus.valid  <= 1'b1;
        seed_bus.seed_a <= a;
        seed_bus.seed_b <= b;
        @(posedge clk);
        while (!seed_bus.ready)
            @(posedge clk);
        expected_words.push_back('{a, b, rc4_keystream(a, b)});
        seed_held = 1'b1;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                // Most rests are short; some outlast a whole item so the block sits idle.
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1200)
                                                  : $urandom_range(0, 20);
                if (gap != 0)
                begin
                    // Junk on the data lines while idle must be ignored by the block.
                    seed_bus.valid  <= 1'b0;
                    seed_bus.seed_a <= 8'($urandom_range(0, 255));
                    seed_bus.seed_b <= 8'($urandom_range(0, 255));
                    seed_held = 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Receiver: ready follows the current stall mode. A stall, once started, runs its
    // full length regardless of whether a word is waiting.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            word_bus.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else
        begin
            word_bus.ready <= 1'b1;
            case (stall_mode)
                STALL_SHORT:
                begin
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 40);
                end
                STALL_LONG:
                begin
                    if ($urandom_range(0, 199) == 0)
                        stall_left <= $urandom_range(200, 1500);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Checks every word transaction against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        keystream_expect_t exp_word;
        if (rst_n && word_bus.valid && word_bus.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("word %h arrived with no seed outstanding",
                                          word_bus.keystream_word));
            else
            begin
                exp_word = expected_words.pop_front();
                if (word_bus.keystream_word !== exp_word.word)
                    report_mismatch($sformatf("seed a=%h b=%h: keystream_word %h, expected %h",
                                              exp_word.seed_a, exp_word.seed_b,
                                              word_bus.keystream_word, exp_word.word));
            end
        end
    end

    // Edges of both fields, wrap-round of the product and of the sums, and alternating bit
    // patterns. Sent back to back with the receiver always ready.
    task automatic test_corner_seeds();
        logic [15:0] pairs [18];
        pairs = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0101, 16'h0100,
                  16'h0001, 16'h8080,   // product zero; for 8080 product and both sums wrap to zero
                  16'h8002,             // product wraps to zero
                  16'h7F81, 16'hFF01,   // sum wraps to zero
                  16'h1010, 16'h55AA, 16'hAA55, 16'h0FF0, 16'hF00F,
                  16'h7F7F, 16'hFE02};
        gaps_on    = 1'b0;
        stall_mode <= STALL_NONE;
        foreach (pairs[p])
            send_seed(pairs[p][15:8], pairs[p][7:0]);
    endtask

    // Transactions are independent: a seed repeated after others must give the same word,
    // whatever indices and state the previous transaction left behind.
    task automatic test_seed_independence();
        gaps_on    = 1'b1;
        burst_left = 0;
        stall_mode <= STALL_SHORT;
        send_seed(8'h3C, 8'hC3);
        send_seed(8'h3C, 8'hC3);
        send_seed(8'hFF, 8'hFF);
        send_seed(8'h3C, 8'hC3);
        send_seed(8'h00, 8'h00);
        send_seed(8'h3C, 8'hC3);
    endtask

    // Random seeds at full rate on both sides.
    task automatic test_random_full_rate(input int count);
        gaps_on    = 1'b0;
        stall_mode <= STALL_NONE;
        repeat (count)
            send_seed(pick_seed_byte(), pick_seed_byte());
    endtask

    // Random seeds with bursty sending and a frequently stalling receiver.
    task automatic test_random_bursty(input int count);
        gaps_on    = 1'b1;
        burst_left = 0;
        stall_mode <= STALL_SHORT;
        repeat (count)
            send_seed(pick_seed_byte(), pick_seed_byte());
    endtask

    // Receiver stalls long enough that a finished word has to wait while the next one is
    // being computed, so the block itself is held back.
    task automatic test_word_backpressure(input int count);
        gaps_on    = 1'b0;
        stall_mode <= STALL_LONG;
        repeat (count)
            send_seed(pick_seed_byte(), pick_seed_byte());
    endtask

    initial
    begin
        seed_bus.valid  = 1'b0;
        seed_bus.seed_a = '0;
        seed_bus.seed_b = '0;
        word_bus.ready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_seeds();
        test_seed_independence();
        test_random_full_rate(150);
        test_random_bursty(430);
        test_word_backpressure(150);

        // Stimulus done: stop sending, let every outstanding word out, then watch for
        // one more item's worth of cycles in case a spurious word turns up.
        if (seed_held)
            seed_bus.valid <= 1'b0;
        stall_mode <= STALL_NONE;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guards against a hung block: a missing word or a seed never accepted ends here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_top

@@ sim.f @@
rtl/rc4sk_pkg.sv
rtl/rc4sk_seed_if.sv
rtl/rc4sk_word_if.sv
rtl/rc4sk_datapath.sv
rtl/rc4sk_ctrl.sv
rtl/rc4_seeded_keystream_word.sv
tb/sv/tb_top.sv
